/* rtl/core/volume_trilinear_gradient_sampler_unit_macros.svh */
// Assertion helpers shared by the sampler RTL.
// Each expects clk and arst_n in scope.
`ifndef VOLUME_TRILINEAR_GRADIENT_SAMPLER_UNIT_MACROS_SVH
`define VOLUME_TRILINEAR_GRADIENT_SAMPLER_UNIT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define VTG_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define VTG_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

/* rtl/core/vtg_pkg.sv */
`timescale 1ns / 1ps
package vtg_pkg;

	localparam int MAX_SIDE_DEF = 64;
	localparam int QUEUE_DEPTH  = 2;

	localparam int SIZE_W  = 7;
	localparam int SCALE_W = 24;
	localparam int T_W     = 32;
	localparam int D_W     = 33;
	localparam int CODE_W  = 8;

	localparam logic [SIZE_W-1:0]  SIZE_RESET  = 7'd64;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd257;

	localparam logic [2:0] LAST_SAMPLE = 3'd6;
	localparam logic [2:0] LAST_CORNER = 3'd7;
	localparam logic [2:0] TOP_BIT     = 3'd6;
	localparam logic [1:0] LAST_COMP   = 2'd2;

	localparam logic [CODE_W-1:0] CODE_MID     = 8'd127;
	localparam logic [CODE_W-1:0] CODE_NEG_TOP = 8'd126;
	localparam logic [CODE_W-1:0] CODE_SAT     = 8'd255;

	typedef enum logic [1:0] {
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_SCALE
	} reg_idx_t;

	typedef enum logic {
		CMD_WRITE,
		CMD_SAMPLE
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_ISSUE,
		F_DRAIN
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQ,
		B_PREP,
		B_CAND,
		B_CMP,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  size_x;
		logic [SIZE_W-1:0]  size_y;
		logic [SIZE_W-1:0]  size_z;
		logic [SCALE_W-1:0] density_scale;
	} cfg_t;

	// centre sample and the three central differences
	typedef struct packed {
		logic [T_W-1:0]        tc;
		logic signed [D_W-1:0] dx;
		logic signed [D_W-1:0] dy;
		logic signed [D_W-1:0] dz;
	} bundle_t;

	typedef struct packed {
		logic [CODE_W-1:0] density_code;
		logic [CODE_W-1:0] normal_x_code;
		logic [CODE_W-1:0] normal_y_code;
		logic [CODE_W-1:0] normal_z_code;
	} result_t;

	// Corner offset plus one along an axis for sample si:
	// 0 centre, 1/2 x-1/x+1, 3/4 y-1/y+1, 5/6 z-1/z+1.
	function automatic logic [1:0] shift_add(input logic [2:0] si, input logic [1:0] axis);
		logic [1:0] r;
		r = 2'd1;
		if (si != 3'd0 && si <= LAST_SAMPLE && 2'((si - 3'd1) >> 1) == axis) begin
			r = si[0] ? 2'd0 : 2'd2;
		end
		return r;
	endfunction

endpackage

/* rtl/core/vtg_ram.sv */
`timescale 1ns / 1ps
module vtg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/vtg_fifo.sv */
`timescale 1ns / 1ps
module vtg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = vtg_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

endmodule

/* rtl/core/vtg_front.sv */
`timescale 1ns / 1ps
`include "volume_trilinear_gradient_sampler_unit_macros.svh"
module vtg_front #(
	parameter int MAX_SIDE = vtg_pkg::MAX_SIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vtg_pkg::cfg_t     cfg,
	input  logic              push,
	output logic              full,
	input  logic              command,
	input  logic [5:0]        voxel_x,
	input  logic [5:0]        voxel_y,
	input  logic [5:0]        voxel_z,
	input  logic [7:0]        voxel_value,
	input  logic [7:0]        frac_x,
	input  logic [7:0]        frac_y,
	input  logic [7:0]        frac_z,
	output logic              q_push,
	output vtg_pkg::bundle_t  q_data,
	input  logic              q_full
);

	localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);

	vtg_pkg::front_state_t state_q, state_d;

	logic [5:0] x_q, y_q, z_q;
	logic [7:0] fx_q, fy_q, fz_q;
	logic [2:0] si_q, ci_q;

	logic       accept, load, issue, ram_we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] ram_rdata;

	logic [8:0] ex, ey, ez;
	logic [6:0] c1x, c1y, c1z;
	logic [8:0] vx, vy, vz;
	logic       cube_ok;
	logic [8:0] wx, wy, wz;

	// read pipeline: s1 RAM data, s2 weight xy, s3 full weight, s4 product
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [2:0]  si_s1, si_s2, si_s3, si_s4;
	logic        in_s1;
	logic [8:0]  wx_s1, wy_s1, wz_s1, wz_s2;
	logic [7:0]  vox_s2, vox_s3;
	logic [16:0] wxy_s2;
	logic [24:0] wxyz_s3;
	logic [31:0] prod_s4;
	logic [31:0] t_q [7];

	function automatic logic [8:0] extent(input logic [6:0] s);
		return (9'(s) > 9'(MAX_SIDE)) ? 9'(MAX_SIDE) : 9'(s);
	endfunction

	assign ex = extent(cfg.size_x);
	assign ey = extent(cfg.size_y);
	assign ez = extent(cfg.size_z);

	assign full   = (state_q != vtg_pkg::F_IDLE);
	assign accept = push && !full;
	assign load   = accept && (command == vtg_pkg::CMD_SAMPLE);
	assign ram_we = accept && (command == vtg_pkg::CMD_WRITE) &&
		(9'(voxel_x) < 9'(MAX_SIDE)) && (9'(voxel_y) < 9'(MAX_SIDE)) &&
		(9'(voxel_z) < 9'(MAX_SIDE));
	assign waddr = AW'(voxel_x) + AW'(MAX_SIDE) * AW'(voxel_y) +
		AW'(MAX_SIDE * MAX_SIDE) * AW'(voxel_z);

	// c1 = cube corner + 1, so a corner of -1 stays non-negative
	assign c1x = 7'(x_q) + 7'(vtg_pkg::shift_add(si_q, 2'd0));
	assign c1y = 7'(y_q) + 7'(vtg_pkg::shift_add(si_q, 2'd1));
	assign c1z = 7'(z_q) + 7'(vtg_pkg::shift_add(si_q, 2'd2));
	assign cube_ok = (c1x != '0) && (9'(c1x) < ex) && (c1y != '0) && (9'(c1y) < ey) &&
		(c1z != '0) && (9'(c1z) < ez);

	assign vx = 9'(c1x) + 9'(ci_q[0]) - 9'd1;
	assign vy = 9'(c1y) + 9'(ci_q[1]) - 9'd1;
	assign vz = 9'(c1z) + 9'(ci_q[2]) - 9'd1;
	assign raddr = AW'(vx[CW-1:0]) + AW'(MAX_SIDE) * AW'(vy[CW-1:0]) +
		AW'(MAX_SIDE * MAX_SIDE) * AW'(vz[CW-1:0]);

	assign wx = ci_q[0] ? 9'(fx_q) : 9'd256 - 9'(fx_q);
	assign wy = ci_q[1] ? 9'(fy_q) : 9'd256 - 9'(fy_q);
	assign wz = ci_q[2] ? 9'(fz_q) : 9'd256 - 9'(fz_q);

	vtg_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(voxel_value),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		q_push  = 1'b0;
		case (state_q)
			vtg_pkg::F_IDLE: begin
				if (load) begin
					state_d = vtg_pkg::F_ISSUE;
				end
			end
			vtg_pkg::F_ISSUE: begin
				issue = 1'b1;
				if (si_q == vtg_pkg::LAST_SAMPLE && ci_q == vtg_pkg::LAST_CORNER) begin
					state_d = vtg_pkg::F_DRAIN;
				end
			end
			vtg_pkg::F_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3 || v_s4) && !q_full) begin
					q_push  = 1'b1;
					state_d = vtg_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = vtg_pkg::F_IDLE;
			end
		endcase
	end

	assign q_data.tc = t_q[0];
	assign q_data.dx = $signed(33'(t_q[1])) - $signed(33'(t_q[2]));
	assign q_data.dy = $signed(33'(t_q[3])) - $signed(33'(t_q[4]));
	assign q_data.dz = $signed(33'(t_q[5])) - $signed(33'(t_q[6]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtg_pkg::F_IDLE;
			si_q    <= '0;
			ci_q    <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (load) begin
				si_q <= '0;
				ci_q <= '0;
			end else if (issue) begin
				ci_q <= ci_q + 1'b1;
				if (ci_q == vtg_pkg::LAST_CORNER) begin
					si_q <= si_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q  <= voxel_x;
			y_q  <= voxel_y;
			z_q  <= voxel_z;
			fx_q <= frac_x;
			fy_q <= frac_y;
			fz_q <= frac_z;
			for (int i = 0; i < 7; i++) begin
				t_q[i] <= '0;
			end
		end else if (v_s4) begin
			t_q[si_s4] <= t_q[si_s4] + prod_s4;
		end
		si_s1   <= si_q;
		in_s1   <= cube_ok;
		wx_s1   <= wx;
		wy_s1   <= wy;
		wz_s1   <= wz;
		si_s2   <= si_s1;
		vox_s2  <= in_s1 ? ram_rdata : 8'd0;
		wxy_s2  <= 17'(wx_s1) * 17'(wy_s1);
		wz_s2   <= wz_s1;
		si_s3   <= si_s2;
		vox_s3  <= vox_s2;
		wxyz_s3 <= 25'(wxy_s2) * 25'(wz_s2);
		si_s4   <= si_s3;
		prod_s4 <= 32'(vox_s3) * 32'(wxyz_s3);
	end

	`VTG_CHECK(a_pipe_origin, v_s1 |-> $past(state_q) == vtg_pkg::F_ISSUE, "read beat without issue")
	`VTG_CHECK(a_push_room, q_push |-> !q_full && !v_s4, "bundle pushed early or into full queue")
	`VTG_CHECK(a_write_idle, ram_we |-> state_q == vtg_pkg::F_IDLE && !v_s1, "voxel write during sample")

endmodule

/* rtl/core/vtg_back.sv */
`timescale 1ns / 1ps
`include "volume_trilinear_gradient_sampler_unit_macros.svh"
module vtg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  vtg_pkg::cfg_t     cfg,
	input  logic              q_empty,
	output logic              q_pop,
	input  vtg_pkg::bundle_t  q_data,
	output logic              o_push,
	output vtg_pkg::result_t  o_data,
	input  logic              o_full
);

	localparam int SW = 66;  // sum of three squares
	localparam int RW = 78;  // 127^2 * d^2
	localparam int QW = 74;  // k * S
	localparam int PW = 82;  // k^2 * S candidate

	vtg_pkg::back_state_t state_q, state_d;

	logic [1:0]  comp_q;
	logic [2:0]  bit_q;
	logic [31:0] tc_q;
	logic signed [32:0] d_q [3];
	logic [63:0] msq_q [3];
	logic [SW-1:0] s_q;
	logic [55:0] prod_q;
	logic [7:0]  dens_q;
	logic [RW-1:0] r_q;
	logic [PW-1:0] p_q, cp_q;
	logic [QW-1:0] q_q, cq_q;
	logic [6:0]  k_q;
	logic        neg_q;
	logic [7:0]  code_q [3];

	logic        d_neg;
	logic [31:0] mag;
	logic [63:0] t255;
	logic [23:0] dens_hi;
	logic        acc;
	logic [6:0]  k_fin;
	logic [7:0]  code_fin;

	assign d_neg   = d_q[comp_q][32];
	assign mag     = 32'(d_neg ? -d_q[comp_q] : d_q[comp_q]);
	assign t255    = (64'(prod_q) << 8) - 64'(prod_q);
	assign dens_hi = t255[63:40];
	assign acc     = neg_q ? (cp_q < PW'(r_q)) : (cp_q <= PW'(r_q));
	assign k_fin   = k_q | (acc ? (7'd1 << bit_q) : 7'd0);
	assign code_fin = (s_q == '0) ? vtg_pkg::CODE_MID :
		neg_q ? vtg_pkg::CODE_NEG_TOP - 8'(k_fin) : vtg_pkg::CODE_MID + 8'(k_fin);

	assign o_data.density_code  = dens_q;
	assign o_data.normal_x_code = code_q[0];
	assign o_data.normal_y_code = code_q[1];
	assign o_data.normal_z_code = code_q[2];

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		o_push  = 1'b0;
		case (state_q)
			vtg_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = vtg_pkg::B_SQ;
				end
			end
			vtg_pkg::B_SQ: begin
				if (comp_q == vtg_pkg::LAST_COMP) begin
					state_d = vtg_pkg::B_PREP;
				end
			end
			vtg_pkg::B_PREP: begin
				state_d = vtg_pkg::B_CAND;
			end
			vtg_pkg::B_CAND: begin
				state_d = vtg_pkg::B_CMP;
			end
			vtg_pkg::B_CMP: begin
				if (bit_q != '0) begin
					state_d = vtg_pkg::B_CAND;
				end else if (comp_q == vtg_pkg::LAST_COMP) begin
					state_d = vtg_pkg::B_OUT;
				end else begin
					state_d = vtg_pkg::B_PREP;
				end
			end
			vtg_pkg::B_OUT: begin
				if (!o_full) begin
					o_push  = 1'b1;
					state_d = vtg_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = vtg_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtg_pkg::B_IDLE;
			comp_q  <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				vtg_pkg::B_IDLE: begin
					comp_q <= '0;
				end
				vtg_pkg::B_SQ: begin
					comp_q <= (comp_q == vtg_pkg::LAST_COMP) ? 2'd0 : comp_q + 1'b1;
				end
				vtg_pkg::B_PREP: begin
					bit_q <= vtg_pkg::TOP_BIT;
				end
				vtg_pkg::B_CMP: begin
					if (bit_q != '0) begin
						bit_q <= bit_q - 1'b1;
					end else begin
						comp_q <= (comp_q == vtg_pkg::LAST_COMP) ? 2'd0 : comp_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// k is found MSB first: k^2*S and k*S are updated by shifts and adds
	always_ff @(posedge clk) begin
		case (state_q)
			vtg_pkg::B_IDLE: begin
				tc_q   <= q_data.tc;
				d_q[0] <= q_data.dx;
				d_q[1] <= q_data.dy;
				d_q[2] <= q_data.dz;
				s_q    <= '0;
			end
			vtg_pkg::B_SQ: begin
				msq_q[comp_q] <= 64'(mag) * 64'(mag);
				s_q <= s_q + SW'(64'(mag) * 64'(mag));
				if (comp_q == 2'd0) begin
					prod_q <= 56'(tc_q) * 56'(cfg.density_scale);
				end else if (comp_q == 2'd1) begin
					dens_q <= (dens_hi[23:8] != '0) ? vtg_pkg::CODE_SAT : dens_hi[7:0];
				end
			end
			vtg_pkg::B_PREP: begin
				r_q   <= (RW'(msq_q[comp_q]) << 14) - (RW'(msq_q[comp_q]) << 8) +
					RW'(msq_q[comp_q]);
				p_q   <= '0;
				q_q   <= '0;
				k_q   <= '0;
				neg_q <= d_neg;
			end
			vtg_pkg::B_CAND: begin
				cp_q <= p_q + (PW'(q_q) << ({1'b0, bit_q} + 4'd1)) +
					(PW'(s_q) << {bit_q, 1'b0});
				cq_q <= q_q + (QW'(s_q) << bit_q);
			end
			vtg_pkg::B_CMP: begin
				if (acc) begin
					p_q <= cp_q;
					q_q <= cq_q;
				end
				k_q <= k_fin;
				if (bit_q == '0) begin
					code_q[comp_q] <= code_fin;
				end
			end
			default: begin
			end
		endcase
	end

	`VTG_CHECK(a_comp_range, comp_q <= vtg_pkg::LAST_COMP, "component index out of range")
	`VTG_CHECK(a_out_room, o_push |-> !o_full && state_q == vtg_pkg::B_OUT, "result pushed into full queue")
	`VTG_CHECK(a_flat_normal, state_q == vtg_pkg::B_OUT && s_q == '0 |-> code_q[0] == vtg_pkg::CODE_MID && code_q[1] == vtg_pkg::CODE_MID && code_q[2] == vtg_pkg::CODE_MID, "zero gradient not mid code")
	`VTG_CHECK_NEXT(a_pop_sq, q_pop, state_q == vtg_pkg::B_SQ && comp_q == 2'd0, "pop not followed by squaring")

endmodule

/* rtl/core/volume_trilinear_gradient_sampler_unit.sv */
`timescale 1ns / 1ps
// Voxel volume sampler: a write item (command 0) stores one byte in the
// MAX_SIDE^3 voxel RAM; a sample item (command 1) returns the scaled
// trilinear density and the normalised central-difference gradient as byte
// codes. Each sample reads 56 voxels (seven shifted cubes of eight) through
// the single read port of the voxel RAM, one per cycle; the back end
// (squares, density scaling and a 7-step bit search per normal component)
// runs on the previous sample meanwhile. Results queue two deep. Voxels must
// be written before being sampled; there is no clearing pass after reset.
// Extent and scale registers sit at byte addresses 0, 4, 8 and 12 and may
// only be changed while idle.
module volume_trilinear_gradient_sampler_unit #(
	parameter int MAX_SIDE = vtg_pkg::MAX_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [5:0]  voxel_x,
	input  logic [5:0]  voxel_y,
	input  logic [5:0]  voxel_z,
	input  logic [7:0]  voxel_value,
	input  logic [7:0]  frac_x,
	input  logic [7:0]  frac_y,
	input  logic [7:0]  frac_z,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  density_code,
	output logic [7:0]  normal_x_code,
	output logic [7:0]  normal_y_code,
	output logic [7:0]  normal_z_code
);

	vtg_pkg::cfg_t    cfg_q;
	vtg_pkg::reg_idx_t reg_idx;
	vtg_pkg::bundle_t f_data, b_data;
	vtg_pkg::result_t r_in, r_out;

	logic cfg_wr;
	logic q_push, q_pop, q_empty, q_full;
	logic o_push, o_full;

	assign pready  = 1'b1;
	assign reg_idx = vtg_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x        <= vtg_pkg::SIZE_RESET;
			cfg_q.size_y        <= vtg_pkg::SIZE_RESET;
			cfg_q.size_z        <= vtg_pkg::SIZE_RESET;
			cfg_q.density_scale <= vtg_pkg::SCALE_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				vtg_pkg::REG_SIZE_X: cfg_q.size_x <= pwdata[6:0];
				vtg_pkg::REG_SIZE_Y: cfg_q.size_y <= pwdata[6:0];
				vtg_pkg::REG_SIZE_Z: cfg_q.size_z <= pwdata[6:0];
				vtg_pkg::REG_SCALE:  cfg_q.density_scale <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			vtg_pkg::REG_SIZE_X: prdata = 32'(cfg_q.size_x);
			vtg_pkg::REG_SIZE_Y: prdata = 32'(cfg_q.size_y);
			vtg_pkg::REG_SIZE_Z: prdata = 32'(cfg_q.size_z);
			vtg_pkg::REG_SCALE:  prdata = 32'(cfg_q.density_scale);
			default:             prdata = '0;
		endcase
	end

	vtg_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.command    (command),
		.voxel_x    (voxel_x),
		.voxel_y    (voxel_y),
		.voxel_z    (voxel_z),
		.voxel_value(voxel_value),
		.frac_x     (frac_x),
		.frac_y     (frac_y),
		.frac_z     (frac_z),
		.q_push     (q_push),
		.q_data     (f_data),
		.q_full     (q_full)
	);

	vtg_fifo #(
		.WIDTH($bits(vtg_pkg::bundle_t)),
		.DEPTH(vtg_pkg::QUEUE_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_push),
		.wdata (f_data),
		.rd    (q_pop),
		.rdata (b_data),
		.empty (q_empty),
		.full  (q_full)
	);

	vtg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.q_data (b_data),
		.o_push (o_push),
		.o_data (r_in),
		.o_full (o_full)
	);

	vtg_fifo #(
		.WIDTH($bits(vtg_pkg::result_t)),
		.DEPTH(vtg_pkg::QUEUE_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (o_push),
		.wdata (r_in),
		.rd    (pop),
		.rdata (r_out),
		.empty (empty),
		.full  (o_full)
	);

	assign density_code  = r_out.density_code;
	assign normal_x_code = r_out.normal_x_code;
	assign normal_y_code = r_out.normal_y_code;
	assign normal_z_code = r_out.normal_z_code;

endmodule

/* tb/sv/volume_trilinear_gradient_sampler_unit_tb.sv */
`timescale 1ns / 1ps
module volume_trilinear_gradient_sampler_unit_tb;

	localparam int SIDE      = 64;
	localparam int LIMIT     = 1200000;
	localparam int DRAIN_GAP = 200;

	class vtg_scoreboard;
		logic [7:0]  vox [0:SIDE*SIDE*SIDE-1];
		logic [6:0]  sz [3];
		logic [23:0] scale;
		vtg_pkg::result_t pending [$];
		int          errs;

		function new();
			sz[0] = vtg_pkg::SIZE_RESET;
			sz[1] = vtg_pkg::SIZE_RESET;
			sz[2] = vtg_pkg::SIZE_RESET;
			scale = vtg_pkg::SCALE_RESET;
			errs = 0;
		endfunction

		function void set_reg(vtg_pkg::reg_idx_t idx, logic [31:0] val);
			case (idx)
				vtg_pkg::REG_SIZE_X: sz[0] = val[6:0];
				vtg_pkg::REG_SIZE_Y: sz[1] = val[6:0];
				vtg_pkg::REG_SIZE_Z: sz[2] = val[6:0];
				vtg_pkg::REG_SCALE:  scale = val[23:0];
				default: begin
				end
			endcase
		endfunction

		function int ext(int a);
			return sz[a] > SIDE ? SIDE : int'(sz[a]);
		endfunction

		function longint unsigned trilin(int x, int y, int z, int fx, int fy, int fz);
			longint unsigned c [2][2];
			longint unsigned r0, r1;
			if (x < 0 || y < 0 || z < 0 || x >= ext(0) - 1 || y >= ext(1) - 1
					|| z >= ext(2) - 1)
				return 0;
			for (int dz = 0; dz < 2; dz++)
				for (int dy = 0; dy < 2; dy++)
					c[dz][dy] = vox[x + SIDE*((y+dy) + SIDE*(z+dz))] * (256 - fx)
						+ vox[x + 1 + SIDE*((y+dy) + SIDE*(z+dz))] * fx;
			r0 = c[0][0] * (256 - fy) + c[0][1] * fy;
			r1 = c[1][0] * (256 - fy) + c[1][1] * fy;
			return r0 * (256 - fz) + r1 * fz;
		endfunction

		// exact floor of 127 + 127*d/sqrt(s) by comparing squares
		function logic [7:0] normal_byte(longint d, logic [127:0] s);
			logic [127:0] mag, rhs, aa;
			int a;
			bit ok;
			mag = d < 0 ? -d : d;
			rhs = mag * mag * 128'd16129;
			for (int c = 254; c >= 0; c--) begin
				a = c - 127;
				aa = a * a;
				if (a == 0)
					ok = d >= 0;
				else if (a > 0)
					ok = d > 0 && s * aa <= rhs;
				else
					ok = d >= 0 || s * aa >= rhs;
				if (ok)
					return c[7:0];
			end
			return 8'd0;
		endfunction

		function void note(logic cmd, int x, int y, int z, logic [7:0] v,
				int fx, int fy, int fz);
			logic [63:0]  t, dens;
			longint       d [3];
			logic [127:0] s;
			vtg_pkg::result_t r;
			if (cmd == vtg_pkg::CMD_WRITE) begin
				vox[x + SIDE*(y + SIDE*z)] = v;
				return;
			end
			t = trilin(x, y, z, fx, fy, fz);
			dens = (t * scale * 64'd255) >> 40;
			r.density_code = dens > 255 ? vtg_pkg::CODE_SAT : dens[7:0];
			d[0] = longint'(trilin(x-1, y, z, fx, fy, fz)) - longint'(trilin(x+1, y, z, fx, fy, fz));
			d[1] = longint'(trilin(x, y-1, z, fx, fy, fz)) - longint'(trilin(x, y+1, z, fx, fy, fz));
			d[2] = longint'(trilin(x, y, z-1, fx, fy, fz)) - longint'(trilin(x, y, z+1, fx, fy, fz));
			s = 0;
			for (int n = 0; n < 3; n++)
				s += 128'(d[n] < 0 ? -d[n] : d[n]) * 128'(d[n] < 0 ? -d[n] : d[n]);
			r.normal_x_code = s == 0 ? vtg_pkg::CODE_MID : normal_byte(d[0], s);
			r.normal_y_code = s == 0 ? vtg_pkg::CODE_MID : normal_byte(d[1], s);
			r.normal_z_code = s == 0 ? vtg_pkg::CODE_MID : normal_byte(d[2], s);
			pending.push_back(r);
		endfunction

		function void check(vtg_pkg::result_t got);
			vtg_pkg::result_t want;
			if (pending.size() == 0) begin
				errs++;
				if (errs <= 10)
					$display("unexpected result beat %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errs++;
				if (errs <= 10)
					$display("mismatch: density %0d/%0d nx %0d/%0d ny %0d/%0d nz %0d/%0d (exp/got)",
						want.density_code, got.density_code, want.normal_x_code,
						got.normal_x_code, want.normal_y_code, got.normal_y_code,
						want.normal_z_code, got.normal_z_code);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        push, full, command;
	logic [5:0]  voxel_x, voxel_y, voxel_z;
	logic [7:0]  voxel_value, frac_x, frac_y, frac_z;
	logic        empty, pop;
	logic [7:0]  density_code, normal_x_code, normal_y_code, normal_z_code;

	vtg_scoreboard sb = new();
	bit   written [0:SIDE*SIDE*SIDE-1];
	int   cur_sz [3];
	bit   idle_on, hold_req;
	int   cycles;

	volume_trilinear_gradient_sampler_unit u_dut (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && push && !full)
			sb.note(command, voxel_x, voxel_y, voxel_z, voxel_value, frac_x, frac_y, frac_z);
		if (arst_n && pop && !empty)
			sb.check('{density_code, normal_x_code, normal_y_code, normal_z_code});
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (600) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic reg_write(vtg_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		if (idx != vtg_pkg::REG_SCALE)
			cur_sz[idx] = int'(val[6:0]) > SIDE ? SIDE : int'(val[6:0]);
	endtask

	task automatic send(logic cmd, int x, int y, int z, logic [7:0] v, int fx, int fy, int fz);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			@(posedge clk);
			push <= 1'b0;
			repeat ($urandom_range(0, 16)) @(posedge clk);
		end else begin
			@(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		voxel_x <= x;
		voxel_y <= y;
		voxel_z <= z;
		voxel_value <= v;
		frac_x <= fx;
		frac_y <= fy;
		frac_z <= fz;
		@(posedge clk);
		while (full)
			@(posedge clk);
		push <= 1'b0;
	endtask

	task automatic put_voxel(int x, int y, int z, logic [7:0] v);
		written[x + SIDE*(y + SIDE*z)] = 1'b1;
		send(vtg_pkg::CMD_WRITE, x, y, z, v, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
	endtask

	function automatic bit cube_ready(int x, int y, int z);
		if (x < 0 || y < 0 || z < 0 || x >= cur_sz[0] - 1 || y >= cur_sz[1] - 1
				|| z >= cur_sz[2] - 1)
			return 1'b1;
		for (int k = 0; k < 8; k++)
			if (!written[(x + k[0]) + SIDE*((y + k[1]) + SIDE*(z + k[2]))])
				return 1'b0;
		return 1'b1;
	endfunction

	// never let a sample touch a voxel that has not been written
	function automatic bit sample_ready(int x, int y, int z);
		return cube_ready(x, y, z) && cube_ready(x-1, y, z) && cube_ready(x+1, y, z)
			&& cube_ready(x, y-1, z) && cube_ready(x, y+1, z)
			&& cube_ready(x, y, z-1) && cube_ready(x, y, z+1);
	endfunction

	function automatic int pick_frac();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic random_item();
		int x, y, z, tries;
		if ($urandom_range(0, 99) < 35) begin
			if ($urandom_range(0, 4) == 0)
				put_voxel($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 255));
			else
				put_voxel($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 9),
					$urandom_range(0, 255));
		end else begin
			tries = 0;
			do begin
				if ($urandom_range(0, 9) == 0) begin
					x = $urandom_range(0, 63);
					y = $urandom_range(0, 63);
					z = $urandom_range(0, 63);
				end else begin
					x = $urandom_range(0, 9);
					y = $urandom_range(0, 9);
					z = $urandom_range(0, 9);
				end
				tries++;
			end while (!sample_ready(x, y, z) && tries < 30);
			if (!sample_ready(x, y, z)) begin
				x = 63;
				y = 63;
				z = 63;
			end
			send(vtg_pkg::CMD_SAMPLE, x, y, z, $urandom_range(0, 255), pick_frac(),
				pick_frac(), pick_frac());
		end
	endtask

	task automatic settle();
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic configure(int sx, int sy, int sz_, logic [23:0] sc);
		settle();
		reg_write(vtg_pkg::REG_SIZE_X, sx);
		reg_write(vtg_pkg::REG_SIZE_Y, sy);
		reg_write(vtg_pkg::REG_SIZE_Z, sz_);
		reg_write(vtg_pkg::REG_SCALE, sc);
	endtask

	initial begin
		int sx, sy, sz_;
		logic [23:0] sc;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		command = vtg_pkg::CMD_WRITE;
		voxel_x = '0;
		voxel_y = '0;
		voxel_z = '0;
		voxel_value = '0;
		frac_x = '0;
		frac_y = '0;
		frac_z = '0;
		cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		cur_sz[0] = SIDE;
		cur_sz[1] = SIDE;
		cur_sz[2] = SIDE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// fill a small block near the origin and the far corner
		for (int i = 0; i < 512; i++)
			put_voxel(i[2:0], i[5:3], i[8:6], $urandom_range(0, 255));
		for (int i = 0; i < 64; i++)
			put_voxel(60 + i[1:0], 60 + i[3:2], 60 + i[5:4], i[0] ? 8'hff : 8'h00);

		// directed: reset and changed settings, edges of the volume, fraction extremes
		send(vtg_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0);
		send(vtg_pkg::CMD_SAMPLE, 1, 1, 1, 8'hff, 255, 255, 255);
		send(vtg_pkg::CMD_SAMPLE, 62, 62, 62, 0, 128, 0, 255);
		send(vtg_pkg::CMD_SAMPLE, 61, 61, 61, 0, 255, 255, 255);
		send(vtg_pkg::CMD_SAMPLE, 63, 63, 63, 0, 17, 34, 51);
		send(vtg_pkg::CMD_SAMPLE, 63, 63, 0, 0, 0, 0, 0);
		put_voxel(63, 63, 63, 8'hff);
		put_voxel(0, 0, 0, 8'h00);
		send(vtg_pkg::CMD_SAMPLE, 0, 0, 0, 0, 255, 0, 128);
		configure(8, 8, 8, 24'hffffff);
		send(vtg_pkg::CMD_SAMPLE, 3, 3, 3, 0, 200, 100, 50);
		send(vtg_pkg::CMD_SAMPLE, 6, 6, 6, 0, 255, 255, 255);
		send(vtg_pkg::CMD_SAMPLE, 7, 0, 0, 0, 0, 0, 0);
		configure(1, 64, 2, 0);
		send(vtg_pkg::CMD_SAMPLE, 0, 0, 0, 0, 9, 9, 9);
		send(vtg_pkg::CMD_SAMPLE, 0, 5, 0, 0, 9, 9, 9);
		configure(2, 2, 2, 257);
		send(vtg_pkg::CMD_SAMPLE, 0, 0, 0, 0, 128, 128, 128);
		configure(127, 0, 100, 65536);
		send(vtg_pkg::CMD_SAMPLE, 4, 4, 4, 0, 1, 2, 3);
		configure(127, 127, 127, 24'h010000);
		send(vtg_pkg::CMD_SAMPLE, 5, 5, 5, 0, 77, 180, 3);

		// back up the result side so the input stalls
		configure(8, 8, 8, 257);
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send(vtg_pkg::CMD_SAMPLE, i % 6, (i + 2) % 6, (i + 4) % 6, 0, pick_frac(),
				pick_frac(), pick_frac());

		for (int ph = 0; ph < 7; ph++) begin
			case ($urandom_range(0, 5))
				0: begin
					sx = $urandom_range(0, 127);
					sy = $urandom_range(0, 127);
					sz_ = $urandom_range(0, 127);
				end
				1: begin
					sx = 64;
					sy = 64;
					sz_ = 64;
				end
				default: begin
					sx = $urandom_range(2, 11);
					sy = $urandom_range(2, 11);
					sz_ = $urandom_range(2, 11);
				end
			endcase
			case ($urandom_range(0, 4))
				0: sc = 0;
				1: sc = 24'hffffff;
				2: sc = 257;
				default: sc = $urandom_range(0, 24'hffffff);
			endcase
			configure(sx, sy, sz_, sc);
			if (ph == 6)
				idle_on = 1'b0;
			for (int i = 0; i < 100; i++)
				random_item();
		end

		settle();
		if (sb.errs == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
